// ===== src/wswm_pkg.sv =====
// Shared types and constants for the word sequence wildcard match block.
// Used by the cell, the top level and the port checker; depends on nothing.
package wswm_pkg;

  localparam int unsigned WordWidth         = 32;
  localparam int unsigned CmdWidth          = 2;
  localparam int unsigned MaxPatternDefault = 16;
  localparam int unsigned InDataWidth       = 40;
  localparam int unsigned OutDataWidth      = 8;

  localparam logic [WordWidth-1:0] WildcardWord = WordWidth'(1);

  localparam logic [CmdWidth-1:0] CmdClear    = 2'd0;
  localparam logic [CmdWidth-1:0] CmdAppend   = 2'd1;
  localparam logic [CmdWidth-1:0] CmdSentence = 2'd2;

  typedef struct packed {
    logic clear_pattern;
    logic append;
    logic step;
    logic clear_progress;
  } cell_ctrl_t;

endpackage

// ===== src/wswm_cell.sv =====
// One position of the pattern: stored word, occupancy flag and partial match bit.
// Depends on wswm_pkg; instantiated in a row by word_sequence_wildcard_match.
module wswm_cell
  import wswm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [WordWidth-1:0] word_i,
  input  logic                 prev_occ_i,
  input  logic                 prev_match_i,
  input  logic                 next_occ_i,
  output logic                 occ_o,
  output logic                 match_o,
  output logic                 done_o
);

  logic [WordWidth-1:0] pat_q;
  logic                 occ_q, occ_d;
  logic                 match_q, match_d;
  logic                 hit;
  logic                 shift_val;
  logic                 load;

  assign load      = ctrl_i.append && prev_occ_i && !occ_q;
  assign hit       = occ_q && ((pat_q == word_i) || (pat_q == WildcardWord));
  assign shift_val = prev_match_i && hit;

  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.clear_pattern) begin
      occ_d = 1'b0;
    end else if (load) begin
      occ_d = 1'b1;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear_progress) begin
      match_d = 1'b0;
    end else if (ctrl_i.step) begin
      match_d = shift_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pat_q <= word_i;
    end
  end

  assign occ_o   = occ_q;
  assign match_o = match_q;
  assign done_o  = ctrl_i.step && shift_val && !next_occ_i;

endmodule

// ===== src/word_sequence_wildcard_match.sv =====
// The result is registered from the last sentence word and is valid in the cycle after.
// One input per cycle unless a result is stalled; every pattern cell compares in parallel.
// The output register takes a new result while the previous one is being read out.
// Reset (rst_ni low, asynchronous) empties the pattern and clears all match progress;
// stored pattern words are not reset and are only read once written.
// Depends on wswm_pkg and wswm_cell.
module word_sequence_wildcard_match
  import wswm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,   // command[1:0], word[33:2], zero pad
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata    // found[0], pattern_too_long[1], zero pad
);

  logic [CmdWidth-1:0]  command;
  logic [WordWidth-1:0] word;
  logic                 accept;
  cell_ctrl_t           ctrl;

  logic [MAX_PATTERN-1:0] occ;
  logic [MAX_PATTERN-1:0] match;
  logic [MAX_PATTERN-1:0] done;
  logic [MAX_PATTERN:0]   prev_occ;
  logic [MAX_PATTERN:0]   prev_match;

  logic overflow_q, overflow_d;
  logic seen_q, seen_d;
  logic seen_now;
  logic emit;
  logic out_valid_q;
  logic found_q, too_long_q;

  assign command = s_axis_tdata[CmdWidth-1:0];
  assign word    = s_axis_tdata[CmdWidth+WordWidth-1:CmdWidth];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.clear_pattern  = accept && (command == CmdClear);
    ctrl.append         = accept && (command == CmdAppend);
    ctrl.step           = accept && (command == CmdSentence);
    ctrl.clear_progress = ctrl.clear_pattern || ctrl.append || (ctrl.step && s_axis_tlast);
  end

  assign prev_occ[0]   = 1'b1;
  assign prev_match[0] = 1'b1;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic next_occ;
    if (j == MAX_PATTERN - 1) begin : g_tail
      assign next_occ = 1'b0;
    end else begin : g_body
      assign next_occ = occ[j+1];
    end

    wswm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .word_i       (word),
      .prev_occ_i   (prev_occ[j]),
      .prev_match_i (prev_match[j]),
      .next_occ_i   (next_occ),
      .occ_o        (occ[j]),
      .match_o      (match[j]),
      .done_o       (done[j])
    );

    assign prev_occ[j+1]   = occ[j];
    assign prev_match[j+1] = match[j];
  end

  assign seen_now = seen_q || !occ[0] || (|done);
  assign emit     = ctrl.step && s_axis_tlast;

  always_comb begin
    overflow_d = overflow_q;
    if (ctrl.clear_pattern) begin
      overflow_d = 1'b0;
    end else if (ctrl.append && occ[MAX_PATTERN-1]) begin
      overflow_d = 1'b1;
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (ctrl.clear_progress) begin
      seen_d = 1'b0;
    end else if (ctrl.step) begin
      seen_d = seen_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q  <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      overflow_q <= overflow_d;
      seen_q     <= seen_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q    <= seen_now && !overflow_q;
      too_long_q <= overflow_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-2){1'b0}}, too_long_q, found_q};

endmodule

// ===== src/wswm_checker.sv =====
// Port-level checks for word_sequence_wildcard_match, bound to the top level.
// Depends on wswm_pkg.
module wswm_checker
  import wswm_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid_i,
  input logic                    s_axis_tready_i,
  input logic [InDataWidth-1:0]  s_axis_tdata_i,
  input logic                    s_axis_tlast_i,
  input logic                    m_axis_tvalid_i,
  input logic                    m_axis_tready_i,
  input logic [OutDataWidth-1:0] m_axis_tdata_i
);

  logic sentence_end;

  assign sentence_end = s_axis_tvalid_i && s_axis_tready_i && s_axis_tlast_i &&
                        (s_axis_tdata_i[CmdWidth-1:0] == CmdSentence);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("Result changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sentence_end |=> m_axis_tvalid_i)
    else $error("Sentence end produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !$past(m_axis_tvalid_i) |-> $past(sentence_end))
    else $error("Result appeared without a sentence end.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(m_axis_tdata_i[0] && m_axis_tdata_i[1]))
    else $error("Found reported with an overlong pattern.");

endmodule

bind word_sequence_wildcard_match wswm_checker u_wswm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid),
  .s_axis_tready_i (s_axis_tready),
  .s_axis_tdata_i  (s_axis_tdata),
  .s_axis_tlast_i  (s_axis_tlast),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);
